// ===== design/assert_macros.svh =====
// Assertion macros shared by the PWM duty meter RTL.
// No dependencies; take in with `include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_CHK(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_CHK(label, clk, rst_n, expr)
`define AST_IMPL(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/pdc_pkg.sv =====
// Types and constants of the two-channel PWM duty meter.
// No dependencies; used by pdc_duty_div and the core.
`default_nettype none

package pdc_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int PRESCALE_W        = 16;
    localparam int DUTY_W            = 10;
    localparam int CH_W              = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int PER_MILLE         = 1000;
    localparam int DUTY_MAX          = 999;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd2399;

    localparam logic [CH_W-1:0] CH_ONE = 2'd1;
    localparam logic [CH_W-1:0] CH_TWO = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd1;

    typedef struct packed {
        logic command;
        logic pin_one;
        logic pin_two;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_first;
        logic [DUTY_W-1:0] duty_second;
        logic [CH_W-1:0]   measuring_channel;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE
    } state_t;

endpackage

`default_nettype wire

// ===== design/pwm_duty_capture_two_channel_core.sv =====
// Two-channel PWM duty meter on a prescaled capture timer.
// Depends on pdc_pkg, pdc_duty_div and assert_macros.svh.
//
// Input channel s_valid/s_ready/s_data carries items: a tick with pin samples
// (command 0) or a poll (command 1). Every item yields exactly one result on
// m_valid/m_ready/m_data: both stored duties in per-mille and the channel
// being measured after the item.
// A tick's result is registered at the same edge that accepts it.
// A poll runs a bit-serial divider, one quotient bit per cycle for ten bits;
// the next item is taken only once the poll's result has been stored.
// One item is in work at a time; a tick may follow a tick each cycle while
// the output register is free or being drained.
// The output register holds a result until taken. While it is full and not
// being drained, s_ready stays low and finished poll work waits.
// Config port cfg_valid/cfg_ready/cfg_index/cfg_data is always ready:
// index 0 is the prescaler reload, index 1 the start channel (1 or 2; it also
// switches the measured channel). Other values are ignored.
// Synchronous active-low aresetn clears counters, captures and duties, sets
// the reload to 2399 and the channel to one, and empties the output.
`default_nettype none

module pwm_duty_capture_two_channel_core #(
    parameter int COUNTER_WIDTH = pdc_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire pdc_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output pdc_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pdc_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = COUNTER_WIDTH;

    state_t                state_reg, state_next;
    logic [PRESCALE_W-1:0] prescale_div_reg, prescale_div_next;
    logic [CH_W-1:0]       start_ch_reg, start_ch_next;
    logic [PRESCALE_W-1:0] presc_reg, presc_next;
    logic [CW-1:0]         timer_reg, timer_next;
    logic                  prev_reg, prev_next;
    logic [CW-1:0]         period_reg, period_next;
    logic [CW-1:0]         high_reg, high_next;
    logic [CH_W-1:0]       active_reg, active_next;
    logic [DUTY_W-1:0]     duty_one_reg, duty_one_next;
    logic [DUTY_W-1:0]     duty_two_reg, duty_two_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic                  out_free;
    logic                  accept;
    logic                  tick_fire;
    logic                  div_start;
    logic                  store_fire;
    logic                  level;
    logic                  rising;
    logic                  falling;
    logic                  cfg_fire;
    logic [CW:0]           rise;
    logic [CW:0]           fall;
    logic [DUTY_W-1:0]     div_duty;
    div_stat_t             div_stat;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign tick_fire = accept && (s_data.command == CMD_TICK);
    assign rise      = {1'b0, period_reg} + (CW + 1)'(1);
    assign fall      = {1'b0, high_reg} + (CW + 1)'(1);

    pdc_duty_div #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .fall   (fall),
        .rise   (rise),
        .stat   (div_stat),
        .duty   (div_duty)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.command == CMD_POLL) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready    = 1'b0;
        div_start  = 1'b0;
        store_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = out_free;
                div_start = s_valid && out_free && (s_data.command == CMD_POLL);
            end
            ST_DIVIDE: begin
            end
            ST_STORE: begin
                store_fire = out_free;
            end
            default: begin
            end
        endcase
    end

    assign level   = (active_reg == CH_TWO) ? s_data.pin_two : s_data.pin_one;
    assign rising  = !prev_reg && level;
    assign falling = prev_reg && !level;

    // capture timer
    always_comb begin
        presc_next  = presc_reg;
        timer_next  = timer_reg;
        prev_next   = prev_reg;
        period_next = period_reg;
        high_next   = high_reg;
        if (tick_fire) begin
            prev_next = level;
            if (rising) begin
                period_next = timer_reg;
                timer_next  = '0;
                presc_next  = '0;
            end else begin
                if (falling) begin
                    high_next = timer_reg;
                end
                if (presc_reg >= prescale_div_reg) begin
                    presc_next = '0;
                    timer_next = timer_reg + CW'(1);
                end else begin
                    presc_next = presc_reg + PRESCALE_W'(1);
                end
            end
        end
    end

    // config, duty stores, channel
    always_comb begin
        prescale_div_next = prescale_div_reg;
        start_ch_next     = start_ch_reg;
        active_next       = active_reg;
        duty_one_next     = duty_one_reg;
        duty_two_next     = duty_two_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_PRESCALE: prescale_div_next = cfg_data[PRESCALE_W-1:0];
                CFG_START: begin
                    if (cfg_data[CH_W-1:0] == CH_ONE || cfg_data[CH_W-1:0] == CH_TWO) begin
                        start_ch_next = cfg_data[CH_W-1:0];
                        active_next   = cfg_data[CH_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
        if (store_fire) begin
            if (active_reg == CH_TWO) begin
                duty_two_next = div_duty;
                active_next   = CH_ONE;
            end else begin
                duty_one_next = div_duty;
                active_next   = CH_TWO;
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (tick_fire || store_fire) begin
            m_valid_next                  = 1'b1;
            m_data_next.duty_first        = duty_one_next;
            m_data_next.duty_second       = duty_two_next;
            m_data_next.measuring_channel = active_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            prescale_div_reg <= PRESCALE_RESET;
            start_ch_reg     <= CH_ONE;
            presc_reg        <= '0;
            timer_reg        <= '0;
            prev_reg         <= 1'b0;
            period_reg       <= '0;
            high_reg         <= '0;
            active_reg       <= CH_ONE;
            duty_one_reg     <= '0;
            duty_two_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            prescale_div_reg <= prescale_div_next;
            start_ch_reg     <= start_ch_next;
            presc_reg        <= presc_next;
            timer_reg        <= timer_next;
            prev_reg         <= prev_next;
            period_reg       <= period_next;
            high_reg         <= high_next;
            active_reg       <= active_next;
            duty_one_reg     <= duty_one_next;
            duty_two_reg     <= duty_two_next;
            m_valid_reg      <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `AST_CHK(a_chan_legal, aclk, aresetn, active_reg == CH_ONE || active_reg == CH_TWO)
    `AST_IMPL(a_done_in_div, aclk, aresetn, div_stat.done, state_reg == ST_DIVIDE)
    `AST_NEXT(a_poll_starts, aclk, aresetn, accept && s_data.command == CMD_POLL,
        state_reg == ST_DIVIDE && div_stat.busy)
    `AST_CHK(a_duty_range, aclk, aresetn,
        duty_one_reg <= DUTY_W'(DUTY_MAX) && duty_two_reg <= DUTY_W'(DUTY_MAX))
    `AST_IMPL(a_start_match, aclk, aresetn, start_ch_reg == CH_TWO || start_ch_reg == CH_ONE,
        !(state_reg == ST_IDLE && div_stat.busy))

endmodule

`default_nettype wire

// ===== design/pdc_duty_div.sv =====
// Bit-serial per-mille divider: duty = fall*1000/rise, or 0 unless rise > fall.
// Depends on pdc_pkg and assert_macros.svh.
`default_nettype none

module pdc_duty_div #(
    parameter int COUNTER_WIDTH = pdc_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [COUNTER_WIDTH:0]        fall,
    input  wire logic [COUNTER_WIDTH:0]        rise,
    output pdc_pkg::div_stat_t                 stat,
    output logic [pdc_pkg::DUTY_W-1:0]         duty
);
    import pdc_pkg::*;
    `include "assert_macros.svh"

    localparam int OW    = COUNTER_WIDTH + 1;
    localparam int NW    = OW + DUTY_W;
    localparam int CNT_W = $clog2(DUTY_W);

    logic [OW-1:0]     rem_reg, rem_next;
    logic [OW-1:0]     dvs_reg, dvs_next;
    logic [DUTY_W-1:0] low_reg, low_next;
    logic [DUTY_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              gt_reg, gt_next;

    logic [NW-1:0]     prod;
    logic [OW:0]       trial;
    logic [OW:0]       dvs_ext;
    logic [OW:0]       diff;
    logic              ge;
    logic              last_step;

    assign prod      = NW'(fall) * NW'(PER_MILLE);
    assign trial     = {rem_reg, low_reg[DUTY_W-1]};
    assign dvs_ext   = {1'b0, dvs_reg};
    assign diff      = trial - dvs_ext;
    assign ge        = trial >= dvs_ext;
    assign last_step = cnt_reg == CNT_W'(DUTY_W - 1);

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        gt_next   = gt_reg;
        if (start) begin
            rem_next  = prod[NW-1:DUTY_W];
            low_next  = prod[DUTY_W-1:0];
            dvs_next  = rise;
            gt_next   = rise > fall;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[OW-1:0] : trial[OW-1:0];
            low_next  = {low_reg[DUTY_W-2:0], 1'b0};
            quot_next = {quot_reg[DUTY_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        gt_reg   <= gt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last_step;
    assign duty      = gt_reg ? quot_reg : '0;

    `AST_IMPL(a_cnt_range, aclk, aresetn, busy_reg, cnt_reg <= CNT_W'(DUTY_W - 1))
    `AST_NEXT(a_done_idle, aclk, aresetn, stat.done && !start, !busy_reg)
    `AST_IMPL(a_duty_range, aclk, aresetn, $past(stat.done), duty <= DUTY_W'(DUTY_MAX))

endmodule

`default_nettype wire

// ===== bench/pwm_duty_checker.sv =====
// Scoreboard for the two-channel PWM duty meter: tracks register writes and
// input items, predicts every result and compares it with the output channel.
// Depends on pdc_pkg for the item structs and register codes.
`timescale 1ns / 1ps

module pwm_duty_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  pdc_pkg::in_item_t                s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  pdc_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               error_count,
    output int                               pending
);
    import pdc_pkg::*;

    localparam int CW = COUNTER_WIDTH_DEF;

    logic [PRESCALE_W-1:0] divide_reg;
    logic [PRESCALE_W-1:0] prescaler;
    logic [CW-1:0]         timer;
    logic [CW-1:0]         period_cap;
    logic [CW-1:0]         high_cap;
    logic                  prev_level;
    logic [CH_W-1:0]       channel;
    logic [DUTY_W-1:0]     duty_one;
    logic [DUTY_W-1:0]     duty_two;
    out_item_t             duty_q[$];

    initial begin
        error_count = 0;
        pending     = 0;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: duty meter mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic clear_meter();
        divide_reg = PRESCALE_RESET;
        prescaler  = '0;
        timer      = '0;
        period_cap = '0;
        high_cap   = '0;
        prev_level = 1'b0;
        channel    = CH_ONE;
        duty_one   = '0;
        duty_two   = '0;
        duty_q.delete();
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PRESCALE: divide_reg = data[PRESCALE_W-1:0];
            CFG_START: begin
                if (data[CH_W-1:0] == CH_ONE || data[CH_W-1:0] == CH_TWO)
                    channel = data[CH_W-1:0];
            end
            default: ;
        endcase
    endtask

    function automatic logic [DUTY_W-1:0] per_mille(input logic [CW-1:0] per,
                                                    input logic [CW-1:0] hi);
        logic [CW:0] rise;
        logic [CW:0] fall;
        longint unsigned q;
        rise = {1'b0, per} + 1'b1;
        fall = {1'b0, hi} + 1'b1;
        q = 0;
        if (rise > fall)
            q = (longint'(fall) * PER_MILLE) / longint'(rise);
        return q[DUTY_W-1:0];
    endfunction

    task automatic meter_step(input in_item_t it);
        logic      lvl;
        out_item_t res;
        logic [DUTY_W-1:0] d;
        if (it.command == CMD_TICK) begin
            lvl = (channel == CH_TWO) ? it.pin_two : it.pin_one;
            if (!prev_level && lvl) begin
                period_cap = timer;
                timer      = '0;
                prescaler  = '0;
            end else begin
                if (prev_level && !lvl)
                    high_cap = timer;
                if (prescaler >= divide_reg) begin
                    prescaler = '0;
                    timer     = timer + 1'b1;
                end else begin
                    prescaler = prescaler + 1'b1;
                end
            end
            prev_level = lvl;
        end else begin
            d = per_mille(period_cap, high_cap);
            if (channel == CH_TWO) begin
                duty_two = d;
                channel  = CH_ONE;
            end else begin
                duty_one = d;
                channel  = CH_TWO;
            end
        end
        res.duty_first        = duty_one;
        res.duty_second       = duty_two;
        res.measuring_channel = channel;
        duty_q.push_back(res);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (duty_q.size() == 0) begin
            flag_error($sformatf("result %0d/%0d ch %0d with no item outstanding",
                                 got.duty_first, got.duty_second,
                                 got.measuring_channel));
        end else begin
            want = duty_q.pop_front();
            if (got.duty_first !== want.duty_first)
                flag_error($sformatf("duty_first %0d, expected %0d",
                                     got.duty_first, want.duty_first));
            if (got.duty_second !== want.duty_second)
                flag_error($sformatf("duty_second %0d, expected %0d",
                                     got.duty_second, want.duty_second));
            if (got.measuring_channel !== want.measuring_channel)
                flag_error($sformatf("measuring_channel %0d, expected %0d",
                                     got.measuring_channel, want.measuring_channel));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_meter();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                meter_step(s_data);
            if (m_valid && m_ready)
                check_result(m_data);
        end
        pending = duty_q.size();
    end

endmodule

// ===== bench/tb_pwm_duty_capture_two_channel_core.sv =====
// Top-level bench for the two-channel PWM duty meter: clock, reset, register
// writes, tick/poll stimulus with random flow control, and the final verdict.
// Depends on pdc_pkg, pwm_duty_capture_two_channel_core and pwm_duty_checker.
`timescale 1ns / 1ps

module tb_pwm_duty_capture_two_channel_core;
    import pdc_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASE_ITEMS  = 120;
    localparam int HOLD_CYCLES  = 320;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [CH_W-1:0]      CH_NONE     = 2'd0;
    localparam logic [CH_W-1:0]      CH_BAD      = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int pending;
    int burst_left;
    int sent;
    bit steady_flow;
    bit hold_req;

    pwm_duty_capture_two_channel_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwm_duty_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("tb_pwm_duty_capture_two_channel_core: done, errors");
        $finish;
    end

    // result side: own stall pattern, plus one long hold-off on request
    initial begin
        int run_left;
        bit ready_lvl;
        run_left  = 0;
        ready_lvl = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    if (steady_flow) begin
                        ready_lvl = ($urandom_range(0, 15) != 0);
                        run_left  = ready_lvl ? $urandom_range(8, 64) : 1;
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                ready_lvl = 1'b1;
                                run_left  = $urandom_range(40, 160);
                            end
                            1, 2: begin
                                ready_lvl = 1'b1;
                                run_left  = $urandom_range(1, 6);
                            end
                            default: begin
                                ready_lvl = 1'b0;
                                run_left  = $urandom_range(1, 6);
                            end
                        endcase
                    end
                end
                m_ready <= ready_lvl;
                run_left--;
            end
        end
    end

    task automatic push_item(input logic cmd, input logic p1, input logic p2);
        int gap;
        in_item_t it;
        it.command = cmd;
        it.pin_one = p1;
        it.pin_two = p2;
        @(negedge aclk);
        if (burst_left == 0) begin
            if (steady_flow) begin
                gap        = ($urandom_range(0, 31) == 0) ? 1 : 0;
                burst_left = $urandom_range(16, 128);
            end else begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent++;
    endtask

    task automatic tick(input logic p1, input logic p2);
        push_item(CMD_TICK, p1, p2);
    endtask

    task automatic poll();
        push_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic tick_run(input logic p1, input logic p2, input int count);
        repeat (count) tick(p1, p2);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        s_valid   <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // independent square waves on both pins, then one poll
    task automatic run_waves(input int span);
        int h1;
        int l1;
        int h2;
        int l2;
        int o1;
        int o2;
        int len;
        int k;
        h1  = $urandom_range(1, span);
        l1  = $urandom_range(1, span);
        h2  = $urandom_range(1, span);
        l2  = $urandom_range(1, span);
        o1  = $urandom_range(0, h1 + l1 - 1);
        o2  = $urandom_range(0, h2 + l2 - 1);
        len = $urandom_range(1, 3) * ((h1 + l1 > h2 + l2) ? h1 + l1 : h2 + l2) + 1;
        for (k = 0; k < len; k++)
            tick(((k + o1) % (h1 + l1)) < h1, ((k + o2) % (h2 + l2)) < h2);
        poll();
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
            push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic [PRESCALE_W-1:0] divide_plan [10];
        logic [PRESCALE_W-1:0] div;
        int phase;
        int target;
        int phase_end;
        int span;
        int waited;

        divide_plan = '{16'd0, 16'd1, 16'd3, 16'd0, 16'd2399,
                        16'd65535, 16'd2, 16'd7, 16'd1, 16'd0};
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        burst_left  = 0;
        sent        = 0;
        steady_flow = 1'b0;
        hold_req    = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // polls straight out of reset, then register corner cases
        poll();
        poll();
        set_register(CFG_PRESCALE, 16'd0);
        set_register(CFG_START, CFG_DATA_W'(CH_TWO));
        set_register(CFG_START, CFG_DATA_W'(CH_NONE));
        set_register(CFG_START, CFG_DATA_W'(CH_BAD));
        set_register(CFG_SPARE_A, 16'hFFFF);
        set_register(CFG_SPARE_B, 16'h0000);

        // channel two waveform with noise on pin one
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b1, 1'b1);
        push_item(CMD_POLL, 1'b1, 1'b1);
        poll();                       // stale captures right after a switch

        set_register(CFG_START, CFG_DATA_W'(CH_ONE));
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b0);
        poll();

        // lower the reload below a running prescaler
        set_register(CFG_PRESCALE, 16'hFFFF);
        tick_run(1'b0, 1'b0, 4);
        set_register(CFG_PRESCALE, 16'd2);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b1, 1'b1);
        push_item(CMD_POLL, 1'b0, 1'b0);

        target = sent + RANDOM_ITEMS;
        phase  = 0;
        while (sent < target) begin
            div = (phase < 10) ? divide_plan[phase] : PRESCALE_W'($urandom_range(0, 15));
            set_register(CFG_PRESCALE, div);
            if ($urandom_range(0, 2) == 0)
                set_register(CFG_START, CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0)
                set_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                             CFG_DATA_W'($urandom));
            if (phase == 2 || phase == 6)
                hold_req = 1'b1;
            span      = (div < 6) ? 4 * (int'(div) + 1) + 2 : 24;
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
                if ($urandom_range(0, 99) < 85)
                    run_waves(span);
                else
                    noise_burst();
            end
            phase++;
        end

        // long high and low runs at full flow
        set_register(CFG_PRESCALE, 16'd0);
        steady_flow = 1'b1;
        tick(1'b0, 1'b0);
        tick(1'b1, 1'b1);
        tick_run(1'b1, 1'b1, 47);
        tick_run(1'b0, 1'b0, 16);
        tick(1'b1, 1'b1);
        poll();
        tick_run(1'b1, 1'b1, 9);
        tick_run(1'b0, 1'b0, 30);
        tick(1'b1, 1'b1);
        poll();
        poll();
        steady_flow = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending != 0) begin
            $display("tb_pwm_duty_capture_two_channel_core: done, errors");
        end else begin
            repeat (TAIL_CYCLES) @(negedge aclk);
            if (error_count == 0)
                $display("tb_pwm_duty_capture_two_channel_core: done, clean");
            else
                $display("tb_pwm_duty_capture_two_channel_core: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/pdc_pkg.sv
design/pdc_duty_div.sv
design/pwm_duty_capture_two_channel_core.sv
bench/pwm_duty_checker.sv
bench/tb_pwm_duty_capture_two_channel_core.sv
